/* hw/rtl/qscg_pkg.sv */
// Shared types and constants of the quad subdivision corner generator.
// Holds the corner codes, the register map and the table of midpoint sources.
// Depends on nothing else.
package qscg_pkg;

  // Widths fixed by the register map and the request format.
  localparam int PADDR_W      = 6;
  localparam int PDATA_W      = 64;
  localparam int QUAD_INDEX_W = 12;
  localparam int LEVEL_W      = 3;
  localparam int REG_IDX_W    = 3;

  // Register indexes; each register sits at byte address 8 * index.
  localparam logic [REG_IDX_W-1:0] REG_CORNER_TL = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CORNER_TR = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CORNER_BR = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CORNER_BL = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SUB_LVL   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_EMIT_LVL  = 3'd5;

  // Corner of a quad; the same codes name the child picked by an index digit.
  typedef enum logic [1:0] {
    CORNER_TL = 2'd0,
    CORNER_TR = 2'd1,
    CORNER_BL = 2'd2,
    CORNER_BR = 2'd3
  } corner_e;

  // The two old corners whose midpoint becomes one new corner.
  typedef struct packed {
    corner_e a;
    corner_e b;
  } src_pair_t;

  // A corner kept unchanged is the midpoint of itself with itself. The centre
  // of a quad always lies on the top-left to bottom-right diagonal.
  function automatic src_pair_t mid_src(corner_e child, corner_e corner);
    src_pair_t p;
    p = '{a: CORNER_TL, b: CORNER_TL};
    unique case (child)
      CORNER_TL: begin
        unique case (corner)
          CORNER_TL: p = '{a: CORNER_TL, b: CORNER_TL};
          CORNER_TR: p = '{a: CORNER_TL, b: CORNER_TR};
          CORNER_BL: p = '{a: CORNER_TL, b: CORNER_BL};
          CORNER_BR: p = '{a: CORNER_TL, b: CORNER_BR};
        endcase
      end
      CORNER_TR: begin
        unique case (corner)
          CORNER_TL: p = '{a: CORNER_TL, b: CORNER_TR};
          CORNER_TR: p = '{a: CORNER_TR, b: CORNER_TR};
          CORNER_BL: p = '{a: CORNER_TL, b: CORNER_BR};
          CORNER_BR: p = '{a: CORNER_TR, b: CORNER_BR};
        endcase
      end
      CORNER_BL: begin
        unique case (corner)
          CORNER_TL: p = '{a: CORNER_TL, b: CORNER_BL};
          CORNER_TR: p = '{a: CORNER_TL, b: CORNER_BR};
          CORNER_BL: p = '{a: CORNER_BL, b: CORNER_BL};
          CORNER_BR: p = '{a: CORNER_BL, b: CORNER_BR};
        endcase
      end
      CORNER_BR: begin
        unique case (corner)
          CORNER_TL: p = '{a: CORNER_TL, b: CORNER_BR};
          CORNER_TR: p = '{a: CORNER_TR, b: CORNER_BR};
          CORNER_BL: p = '{a: CORNER_BL, b: CORNER_BR};
          CORNER_BR: p = '{a: CORNER_BR, b: CORNER_BR};
        endcase
      end
    endcase
    return p;
  endfunction

endpackage

/* hw/rtl/quad_subdivision_corner_gen.sv */
// Top level of the quad subdivision corner generator: register port,
// request and result channels, and the bit-serial midpoint datapath.
// Depends on qscg_pkg.
//
// Usage. Software writes the four root corners, the subdivision depth and the
// emit level through the APB-style port (64-bit registers at byte address
// 8 * index); a read returns the stored value. Registers must be written by
// software only while no request is in flight; the block does not enforce it.
// A request carries a quad index; its result carries the four corners of the
// selected quad and a valid flag; an out-of-range request gives zero corners.
// Both channels use valid/ready; a transfer happens when both are high.
// Datapath. Each corner coordinate lives in a shift register and is averaged
// with its partner one bit per cycle; all twelve coordinates advance together,
// one subdivision level after another. A rejected request or one of zero
// levels skips the averaging. One request is worked on at a time.
// Stalls. A finished result moves into the output register; the next request
// is taken while it waits. If the output register is still full when a result
// finishes, the datapath holds it and takes no request until the receiver
// accepts. Reset clears the registers to zero and empties the block.
module quad_subdivision_corner_gen #(
  parameter int MAX_LEVELS = 6,
  parameter int COORD_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [qscg_pkg::PADDR_W-1:0]      paddr,
  input  logic [qscg_pkg::PDATA_W-1:0]      pwdata,
  output logic [qscg_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready,
  // request channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [qscg_pkg::QUAD_INDEX_W-1:0] quad_index_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [3*COORD_BITS-1:0]           top_left_out_o,
  output logic [3*COORD_BITS-1:0]           top_right_out_o,
  output logic [3*COORD_BITS-1:0]           bottom_left_out_o,
  output logic [3*COORD_BITS-1:0]           bottom_right_out_o,
  output logic                              index_valid_o
);
  import qscg_pkg::*;

  localparam int N     = COORD_BITS;
  localparam int CW    = 3 * COORD_BITS;
  localparam int LVL_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int DIG_W = 2 * (1 << LVL_W);
  localparam int BIT_W = $clog2(COORD_BITS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_e;

  // Configuration registers.
  logic [CW-1:0]      cfg_tl_q, cfg_tr_q, cfg_br_q, cfg_bl_q;
  logic [LEVEL_W-1:0] sub_levels_q, emit_level_q;

  // Control.
  state_e             state_q;
  logic [BIT_W-1:0]   bit_q;
  logic [LVL_W-1:0]   lvl_q;
  logic               out_valid_q;

  // Datapath: one shift register per corner coordinate, least significant bit
  // at position zero, with a carry and a pending top bit for each.
  logic [N-1:0]       crd_q [4][3];
  logic [N-1:0]       crd_d [4][3];
  logic [3:0][2:0]    carry_q, carry_d;
  logic [3:0][2:0]    top_q, top_d;
  logic [DIG_W-1:0]   digits_q;
  logic               req_ok_q;

  // Result register.
  logic [CW-1:0]      res_q [4];
  logic               index_valid_q;

  logic               wr_en;
  logic [REG_IDX_W-1:0] reg_idx;
  logic               in_xfer;
  logic [LEVEL_W-1:0] levels;
  logic               req_ok;
  logic               bit_last;
  corner_e            digit;
  logic [CW-1:0]      packed_crd [4];

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1 -: REG_IDX_W];
  assign wr_en   = psel & penable & pwrite & pready;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_tl_q     <= '0;
      cfg_tr_q     <= '0;
      cfg_br_q     <= '0;
      cfg_bl_q     <= '0;
      sub_levels_q <= '0;
      emit_level_q <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_CORNER_TL: cfg_tl_q     <= pwdata[CW-1:0];
        REG_CORNER_TR: cfg_tr_q     <= pwdata[CW-1:0];
        REG_CORNER_BR: cfg_br_q     <= pwdata[CW-1:0];
        REG_CORNER_BL: cfg_bl_q     <= pwdata[CW-1:0];
        REG_SUB_LVL:   sub_levels_q <= pwdata[LEVEL_W-1:0];
        REG_EMIT_LVL:  emit_level_q <= pwdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (reg_idx)
      REG_CORNER_TL: prdata = PDATA_W'(cfg_tl_q);
      REG_CORNER_TR: prdata = PDATA_W'(cfg_tr_q);
      REG_CORNER_BR: prdata = PDATA_W'(cfg_br_q);
      REG_CORNER_BL: prdata = PDATA_W'(cfg_bl_q);
      REG_SUB_LVL:   prdata = PDATA_W'(sub_levels_q);
      REG_EMIT_LVL:  prdata = PDATA_W'(emit_level_q);
      default:       prdata = '0;
    endcase
  end

  // Request check: depth within range, emit level not above the depth, and no
  // index digits beyond the levels walked.
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i & in_ready_o;
  assign levels     = sub_levels_q - emit_level_q;
  assign req_ok     = (int'(sub_levels_q) <= MAX_LEVELS) &&
                      (emit_level_q <= sub_levels_q) &&
                      ((quad_index_i >> {levels, 1'b0}) == '0);
  assign bit_last   = (bit_q == BIT_W'(N));
  assign digit      = corner_e'(digits_q[{lvl_q, 1'b0} +: 2]);

  // Next datapath values: load on a transfer, then one bit of every midpoint
  // sum per cycle. The sum bit of the first cycle is dropped and the sign bit
  // of the sum enters in the extra cycle, which halves each sum.
  always_comb begin
    src_pair_t pair;
    logic      a, b, s, co;
    crd_d   = crd_q;
    carry_d = carry_q;
    top_d   = top_q;
    pair    = '{a: CORNER_TL, b: CORNER_TL};
    a       = 1'b0;
    b       = 1'b0;
    s       = 1'b0;
    co      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          carry_d = '0;
          for (int c = 0; c < 3; c++) begin
            crd_d[CORNER_TL][c] = req_ok ? cfg_tl_q[c*N +: N] : '0;
            crd_d[CORNER_TR][c] = req_ok ? cfg_tr_q[c*N +: N] : '0;
            crd_d[CORNER_BL][c] = req_ok ? cfg_bl_q[c*N +: N] : '0;
            crd_d[CORNER_BR][c] = req_ok ? cfg_br_q[c*N +: N] : '0;
          end
        end
      end
      ST_RUN: begin
        for (int j = 0; j < 4; j++) begin
          for (int c = 0; c < 3; c++) begin
            if (bit_last) begin
              crd_d[j][c]   = {top_q[j][c], crd_q[j][c][N-1:1]};
              carry_d[j][c] = 1'b0;
            end else begin
              pair          = mid_src(digit, corner_e'(j));
              a             = crd_q[pair.a][c][0];
              b             = crd_q[pair.b][c][0];
              s             = a ^ b ^ carry_q[j][c];
              co            = (a & b) | (carry_q[j][c] & (a ^ b));
              crd_d[j][c]   = {s, crd_q[j][c][N-1:1]};
              carry_d[j][c] = co;
              top_d[j][c]   = a ^ b ^ co;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    crd_q   <= crd_d;
    carry_q <= carry_d;
    top_q   <= top_d;
    if (in_xfer) begin
      digits_q <= DIG_W'(quad_index_i);
      req_ok_q <= req_ok;
    end
  end

  // Corners packed back into the register layout.
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      for (int c = 0; c < 3; c++) begin
        packed_crd[j][c*N +: N] = crd_q[j][c];
      end
    end
  end

  // Sequencer and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      bit_q         <= '0;
      lvl_q         <= '0;
      out_valid_q   <= 1'b0;
      index_valid_q <= 1'b0;
      for (int j = 0; j < 4; j++) begin
        res_q[j] <= '0;
      end
    end else begin
      // The output register empties on a transfer unless a new result
      // replaces it in the same cycle.
      if (out_valid_q && out_ready_i && (state_q != ST_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            bit_q <= '0;
            lvl_q <= LVL_W'(levels - 1'b1);
            if (req_ok && (levels != '0)) begin
              state_q <= ST_RUN;
            end else begin
              state_q <= ST_FINISH;
            end
          end
        end
        ST_RUN: begin
          if (bit_last) begin
            bit_q <= '0;
            if (lvl_q == '0) begin
              state_q <= ST_FINISH;
            end else begin
              lvl_q <= lvl_q - 1'b1;
            end
          end else begin
            bit_q <= bit_q + 1'b1;
          end
        end
        ST_FINISH: begin
          if (!out_valid_q || out_ready_i) begin
            for (int j = 0; j < 4; j++) begin
              res_q[j] <= packed_crd[j];
            end
            index_valid_q <= req_ok_q;
            out_valid_q   <= 1'b1;
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o        = out_valid_q;
  assign top_left_out_o     = res_q[CORNER_TL];
  assign top_right_out_o    = res_q[CORNER_TR];
  assign bottom_left_out_o  = res_q[CORNER_BL];
  assign bottom_right_out_o = res_q[CORNER_BR];
  assign index_valid_o      = index_valid_q;

endmodule

/* sim/quad_subdivision_corner_checker.sv */
// Scoreboard for the quad subdivision corner generator: watches the register
// port, the request channel and the result channel, predicts each quad's corners.
// Depends on qscg_pkg for the corner codes and the register map.
`timescale 1ns / 1ps

module quad_subdivision_corner_checker #(
  parameter int MAX_LEVELS = 6,
  parameter int COORD_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // register port, observed only
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [qscg_pkg::PADDR_W-1:0]      paddr,
  input  logic [qscg_pkg::PDATA_W-1:0]      pwdata,
  input  logic                              pready,
  // request channel
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic [qscg_pkg::QUAD_INDEX_W-1:0] quad_index_i,
  // result channel
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic [3*COORD_BITS-1:0]           top_left_i,
  input  logic [3*COORD_BITS-1:0]           top_right_i,
  input  logic [3*COORD_BITS-1:0]           bottom_left_i,
  input  logic [3*COORD_BITS-1:0]           bottom_right_i,
  input  logic                              index_valid_i,
  // status for the testbench top
  output int unsigned                       errors_o,
  output int unsigned                       pending_o
);
  import qscg_pkg::*;

  localparam int CORNER_W = 3 * COORD_BITS;

  typedef struct {
    int x;
    int y;
    int z;
  } point_t;

  typedef struct packed {
    logic [CORNER_W-1:0] tl;
    logic [CORNER_W-1:0] tr;
    logic [CORNER_W-1:0] bl;
    logic [CORNER_W-1:0] br;
    logic                ok;
  } quad_corners_t;

  // Shadow copy of the register file, kept up to date from observed writes.
  logic [CORNER_W-1:0] root_tl, root_tr, root_br, root_bl;
  logic [LEVEL_W-1:0]  depth_cfg, emit_cfg;

  quad_corners_t quad_corners_q[$];
  quad_corners_t oldest;
  int unsigned   mismatch_count = 0;

  function automatic point_t to_point(logic [CORNER_W-1:0] v);
    point_t p;
    p.x = $signed(v[2*COORD_BITS +: COORD_BITS]);
    p.y = $signed(v[COORD_BITS +: COORD_BITS]);
    p.z = $signed(v[0 +: COORD_BITS]);
    return p;
  endfunction

  function automatic logic [CORNER_W-1:0] from_point(point_t p);
    return {COORD_BITS'(p.x), COORD_BITS'(p.y), COORD_BITS'(p.z)};
  endfunction

  // Midpoint rounded towards minus infinity: the arithmetic shift floors the
  // halved difference.
  function automatic point_t halfway(point_t a, point_t b);
    point_t m;
    m.x = a.x + ((b.x - a.x) >>> 1);
    m.y = a.y + ((b.y - a.y) >>> 1);
    m.z = a.z + ((b.z - a.z) >>> 1);
    return m;
  endfunction

  // Walks the index digits down from the root quad, one level per digit.
  function automatic quad_corners_t predict_quad(logic [QUAD_INDEX_W-1:0] idx);
    quad_corners_t q;
    point_t        tl, tr, bl, br, top, left, ctr, right, bot;
    int            levels;
    int            k;
    corner_e       digit;
    q = '0;
    if (depth_cfg > MAX_LEVELS || emit_cfg > depth_cfg) return q;
    levels = int'(depth_cfg) - int'(emit_cfg);
    if ((32'(idx) >> (2 * levels)) != 0) return q;
    tl = to_point(root_tl);
    tr = to_point(root_tr);
    br = to_point(root_br);
    bl = to_point(root_bl);
    for (k = 0; k < levels; k++) begin
      digit = corner_e'(idx[2*(levels-1-k) +: 2]);
      top   = halfway(tl, tr);
      left  = halfway(tl, bl);
      ctr   = halfway(tl, br);
      right = halfway(tr, br);
      bot   = halfway(bl, br);
      case (digit)
        CORNER_TL: begin
          tr = top;
          br = ctr;
          bl = left;
        end
        CORNER_TR: begin
          tl = top;
          br = right;
          bl = ctr;
        end
        CORNER_BL: begin
          tl = left;
          tr = ctr;
          br = bot;
        end
        default: begin
          tl = ctr;
          tr = right;
          bl = bot;
        end
      endcase
    end
    q.tl = from_point(tl);
    q.tr = from_point(tr);
    q.bl = from_point(bl);
    q.br = from_point(br);
    q.ok = 1'b1;
    return q;
  endfunction

  task automatic compare_field(input string field, input logic [CORNER_W-1:0] want,
                               input logic [CORNER_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %h, actual %h", field, want, got);
      mismatch_count++;
    end
  endtask

  // All observation happens on the rising edge, with values as they stood
  // before the edge. Results are retired before a new request is queued.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_tl   = '0;
      root_tr   = '0;
      root_br   = '0;
      root_bl   = '0;
      depth_cfg = '0;
      emit_cfg  = '0;
      quad_corners_q.delete();
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (quad_corners_q.size() == 0) begin
          $error("result transfer with no request outstanding");
          mismatch_count++;
        end else begin
          oldest = quad_corners_q.pop_front();
          compare_field("top_left_out", oldest.tl, top_left_i);
          compare_field("top_right_out", oldest.tr, top_right_i);
          compare_field("bottom_left_out", oldest.bl, bottom_left_i);
          compare_field("bottom_right_out", oldest.br, bottom_right_i);
          compare_field("index_valid", CORNER_W'(oldest.ok), CORNER_W'(index_valid_i));
        end
      end

      // A new request joins the tail of the queue.
      if (in_valid_i && in_ready_i) begin
        quad_corners_q.insert(quad_corners_q.size(), predict_quad(quad_index_i));
      end

      // Register writes; bits above a register's width are dropped.
      if (psel && penable && pwrite && pready) begin
        case (paddr[PADDR_W-1:3])
          REG_CORNER_TL: root_tl = pwdata[CORNER_W-1:0];
          REG_CORNER_TR: root_tr = pwdata[CORNER_W-1:0];
          REG_CORNER_BR: root_br = pwdata[CORNER_W-1:0];
          REG_CORNER_BL: root_bl = pwdata[CORNER_W-1:0];
          REG_SUB_LVL:   depth_cfg = pwdata[LEVEL_W-1:0];
          REG_EMIT_LVL:  emit_cfg = pwdata[LEVEL_W-1:0];
          default: ;
        endcase
      end

      pending_o <= quad_corners_q.size();
      errors_o  <= mismatch_count;
    end
  end

endmodule

/* sim/quad_subdivision_corner_gen_test.sv */
// Testbench top for the quad subdivision corner generator: clock, reset,
// register set-up, request stimulus and receiver stalls, plus the verdict.
// Depends on qscg_pkg, quad_subdivision_corner_gen and the corner checker.
`timescale 1ns / 1ps

module quad_subdivision_corner_gen_test;
  import qscg_pkg::*;

  localparam int MAX_LEVELS = 6;
  localparam int COORD_BITS = 16;
  localparam int CORNER_W   = 3 * COORD_BITS;

  // Corners whose coordinates sit at the signed extremes, so that midpoints
  // see the widest differences in both directions.
  localparam logic [CORNER_W-1:0] EDGE_TL = {16'h7FFF, 16'h8000, 16'h7FFF};
  localparam logic [CORNER_W-1:0] EDGE_TR = {16'h8000, 16'h7FFF, 16'h8000};
  localparam logic [CORNER_W-1:0] EDGE_BR = {16'h8000, 16'h8000, 16'h7FFF};
  localparam logic [CORNER_W-1:0] EDGE_BL = {16'h7FFF, 16'h7FFF, 16'h8000};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [PADDR_W-1:0]      paddr = '0;
  logic [PDATA_W-1:0]      pwdata = '0;
  logic [PDATA_W-1:0]      prdata;
  logic                    pready;

  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [QUAD_INDEX_W-1:0] quad_index_i = '0;

  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic [CORNER_W-1:0]     top_left_out_o, top_right_out_o;
  logic [CORNER_W-1:0]     bottom_left_out_o, bottom_right_out_o;
  logic                    index_valid_o;

  int unsigned errors, pending;
  int unsigned burst_left = 0;
  int unsigned ready_hold = 0;

  always #10 clk_i = ~clk_i;

  quad_subdivision_corner_gen #(
    .MAX_LEVELS(MAX_LEVELS),
    .COORD_BITS(COORD_BITS)
  ) uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .quad_index_i       (quad_index_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .top_left_out_o     (top_left_out_o),
    .top_right_out_o    (top_right_out_o),
    .bottom_left_out_o  (bottom_left_out_o),
    .bottom_right_out_o (bottom_right_out_o),
    .index_valid_o      (index_valid_o)
  );

  quad_subdivision_corner_checker #(
    .MAX_LEVELS(MAX_LEVELS),
    .COORD_BITS(COORD_BITS)
  ) checker_inst (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .quad_index_i   (quad_index_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .top_left_i     (top_left_out_o),
    .top_right_i    (top_right_out_o),
    .bottom_left_i  (bottom_left_out_o),
    .bottom_right_i (bottom_right_out_o),
    .index_valid_i  (index_valid_o),
    .errors_o       (errors),
    .pending_o      (pending)
  );

  // Receiver: alternates ready runs and stall runs of random length, with the
  // odd long stretch of uninterrupted readiness.
  always @(posedge clk_i) begin
    if (ready_hold == 0) begin
      if (out_ready_i) begin
        out_ready_i <= 1'b0;
        ready_hold  <= $urandom_range(1, 8);
      end else begin
        out_ready_i <= 1'b1;
        ready_hold  <= ($urandom_range(0, 4) == 0) ? $urandom_range(30, 200)
                                                   : $urandom_range(1, 10);
      end
    end else begin
      ready_hold <= ready_hold - 1;
    end
  end

  // One register write: setup phase, access phase, then the bus returns to idle.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                           input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 3'b000});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drain every outstanding request, then load a new root quad and levels.
  // Unused upper register bits carry random junk, which must be ignored.
  task automatic set_quad_frame(input logic [CORNER_W-1:0] tl, input logic [CORNER_W-1:0] tr,
                                input logic [CORNER_W-1:0] br, input logic [CORNER_W-1:0] bl,
                                input logic [LEVEL_W-1:0] depth,
                                input logic [LEVEL_W-1:0] emit);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    write_reg(REG_CORNER_TL, {16'($urandom), tl});
    write_reg(REG_CORNER_TR, {16'($urandom), tr});
    write_reg(REG_CORNER_BR, {16'($urandom), br});
    write_reg(REG_CORNER_BL, {16'($urandom), bl});
    write_reg(REG_SUB_LVL, {61'({$urandom, $urandom}), depth});
    write_reg(REG_EMIT_LVL, {61'({$urandom, $urandom}), emit});
  endtask

  // Present one request and hold it until transferred; bursts end in a gap.
  task automatic send_quad(input logic [QUAD_INDEX_W-1:0] idx);
    in_valid_i   <= 1'b1;
    quad_index_i <= idx;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 100)
                                               : $urandom_range(1, 8);
      in_valid_i <= 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(20, 120)
                                          : $urandom_range(1, 6)) @(posedge clk_i);
    end else begin
      burst_left--;
    end
  endtask

  function automatic logic [COORD_BITS-1:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [CORNER_W-1:0] rand_corner();
    return {rand_coord(), rand_coord(), rand_coord()};
  endfunction

  // Random phases: depth mostly legal, emit mostly at or below depth, and
  // indexes mostly inside the quad count of that setting.
  task automatic run_random_phase(input int unsigned count);
    logic [LEVEL_W-1:0] depth, emit;
    int                 levels;
    int unsigned        n;
    depth = ($urandom_range(0, 9) == 0) ? LEVEL_W'(7) : LEVEL_W'($urandom_range(0, 6));
    if ($urandom_range(0, 7) == 0) emit = LEVEL_W'($urandom_range(0, 7));
    else if ($urandom_range(0, 1) == 0) emit = '0;
    else emit = LEVEL_W'($urandom_range(0, depth));
    set_quad_frame(rand_corner(), rand_corner(), rand_corner(), rand_corner(), depth, emit);
    levels = int'(depth) - int'(emit);
    for (n = 0; n < count; n++) begin
      if (depth <= MAX_LEVELS && levels >= 0 && $urandom_range(0, 9) < 8)
        send_quad(QUAD_INDEX_W'($urandom_range(0, (1 << (2 * levels)) - 1)));
      else
        send_quad(QUAD_INDEX_W'($urandom_range(0, 4095)));
    end
  endtask

  initial begin
    int p;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Registers straight out of reset: zero levels, only index zero is valid.
    send_quad(12'd0);
    send_quad(12'd1);
    send_quad(12'hFFF);

    // Full depth on extreme corners: all-TL, all-TR, all-BL, all-BR paths.
    set_quad_frame(EDGE_TL, EDGE_TR, EDGE_BR, EDGE_BL, 3'd6, 3'd0);
    send_quad(12'h000);
    send_quad(12'h555);
    send_quad(12'hAAA);
    send_quad(12'hFFF);
    send_quad(12'h1B4);
    send_quad(12'hE4B);

    // Emit level above leaves: two levels, last in-range index and the next.
    set_quad_frame(EDGE_BL, EDGE_BR, EDGE_TL, EDGE_TR, 3'd3, 3'd1);
    send_quad(12'd0);
    send_quad(12'd6);
    send_quad(12'd15);
    send_quad(12'd16);
    send_quad(12'hFFF);

    // Emit level above depth.
    set_quad_frame(EDGE_TL, EDGE_TR, EDGE_BR, EDGE_BL, 3'd2, 3'd5);
    send_quad(12'd0);
    send_quad(12'd3);

    // Depth above the supported maximum.
    set_quad_frame(EDGE_TL, EDGE_TR, EDGE_BR, EDGE_BL, 3'd7, 3'd0);
    send_quad(12'd0);
    send_quad(12'd9);

    // Emit level equal to depth: the root quad itself.
    set_quad_frame(EDGE_TR, EDGE_TL, EDGE_BL, EDGE_BR, 3'd6, 3'd6);
    send_quad(12'd0);
    send_quad(12'd1);

    // Emit level at its maximum with depth also beyond range.
    set_quad_frame('0, '1, '0, '1, 3'd7, 3'd7);
    send_quad(12'd0);

    for (p = 0; p < 10; p++) run_random_phase(65);

    // Drain, then give the datapath a full deep request's time to settle.
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
    if (errors == 0 && pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Watchdog: 15 ms is several times the slowest legal run.
  initial begin
    #(15_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
